@@ hdl/crp_pkg.sv @@
package crp_pkg;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_CHUNK = 2'd1;
	localparam logic [1:0] REQ_POLL  = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BUSY     = 3'd1;
	localparam logic [2:0] ST_BAD_CH   = 3'd2;
	localparam logic [2:0] ST_BAD_CNT  = 3'd3;
	localparam logic [2:0] ST_BAD_RATE = 3'd4;

	localparam logic [1:0] POLL_IDLE    = 2'd0;
	localparam logic [1:0] POLL_RUNNING = 2'd1;
	localparam logic [1:0] POLL_DONE    = 2'd2;

	localparam logic [31:0] TIMER_CLK = 32'd144000000;
	localparam logic [31:0] NS_PER_S  = 32'd1000000000;
	localparam logic [31:0] MIN_TICKS = 32'd10;
	localparam logic [31:0] PSC_SPAN  = 32'd65536;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] rate_hz;
		logic [31:0] sample_count;
		logic [7:0]  channel_mask;
		logic        other_busy;
	} in_t;

	typedef struct packed {
		logic [2:0]  start_status;
		logic [15:0] prescaler;
		logic [15:0] reload;
		logic [23:0] achieved_rate_hz;
		logic        chunk_valid;
		logic [14:0] chunk_offset;
		logic [15:0] chunk_length;
		logic        stop_capture;
		logic [1:0]  poll_state;
		logic [15:0] report_samples;
		logic [7:0]  report_mask;
	} out_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	// minimum sample period in ns for n channels: floor(n * 20000 / 9)
	function automatic logic [14:0] min_period_ns(input logic [3:0] n);
		logic [14:0] v;
		unique case (n)
			4'd1: v = 15'd2222;
			4'd2: v = 15'd4444;
			4'd3: v = 15'd6666;
			4'd4: v = 15'd8888;
			4'd5: v = 15'd11111;
			4'd6: v = 15'd13333;
			4'd7: v = 15'd15555;
			4'd8: v = 15'd17777;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/crp_if.sv @@
interface crp_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/crp_div.sv @@
module crp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  crp_pkg::div_req_t req,
	output crp_pkg::div_rsp_t rsp
);
	import crp_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end else if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

@@ hdl/capture_rate_planner_and_chunker.sv @@
// Capture planner: one item at a time. Chunk-done and poll items go from transfer
// straight to the output state; a start rejected by the busy, channel, count or
// zero-rate check first passes the check state. A start that reaches planning runs
// three or four divisions on one shared restoring divider (period, reload when the
// prescaler is non-zero, achieved rate, requested period in ns); a period that is too
// short, or a reload out of range, ends planning early.
// The result sits in an output register, so the next item is taken while it waits.
module capture_rate_planner_and_chunker #(
	parameter int BUFFER_BYTES = 65536,
	parameter int MAX_CHUNK    = 65535
) (
	input logic clk,
	input logic arst_n,
	crp_if.sink   req_ch,
	crp_if.source rsp_ch
);
	import crp_pkg::*;

	localparam int HALF = BUFFER_BYTES / 2;
	localparam int HW_W = (HALF < 2) ? 1 : $clog2(HALF + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_DIV1 = 4'd2;
	localparam logic [3:0] S_PLAN = 4'd3;
	localparam logic [3:0] S_DIV2 = 4'd4;
	localparam logic [3:0] S_ARR  = 4'd5;
	localparam logic [3:0] S_DIV3 = 4'd6;
	localparam logic [3:0] S_DIV4 = 4'd7;
	localparam logic [3:0] S_PUT  = 4'd8;

	logic [3:0]  state_q;
	in_t         item_q;
	logic [3:0]  nch_q;
	logic [2:0]  st_q;
	logic [27:0] period_q;
	logic [15:0] psc_q;
	logic [15:0] arr_q;
	logic [23:0] ach_q;
	logic [HW_W-1:0] total_q;

	logic            capturing_q;
	logic            finished_q;
	logic [HW_W-1:0] hw_left_q;
	logic [HW_W-1:0] boff_q;
	logic [15:0]     chunk_q;
	logic [HW_W-1:0] samples_q;
	logic [7:0]      mask_q;
	logic [23:0]     rate_q;

	out_t out_q;
	out_t out_c;
	logic out_valid_q;

	div_req_t dreq;
	div_rsp_t drsp;

	crp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [3:0]  nch_c;
	logic [35:0] total_c;
	logic [27:0] psc_c;
	logic [16:0] psc1;
	logic [16:0] arr1;
	logic [33:0] prod;
	logic        out_free;

	always_comb begin
		nch_c = '0;
		for (int i = 0; i < 8; i++) nch_c = nch_c + 4'(item_q.channel_mask[i]);
	end

	assign total_c  = item_q.sample_count * nch_c;
	assign psc_c    = (period_q - 28'd1) >> 16;
	assign psc1     = {1'b0, psc_q} + 17'd1;
	assign arr1     = {1'b0, arr_q} + 17'd1;
	assign prod     = psc1 * arr1;
	assign out_free = !out_valid_q || rsp_ch.ready;

	always_comb begin
		dreq = '0;
		unique case (state_q)
			S_CHK: begin
				dreq.dividend = TIMER_CLK;
				dreq.divisor  = item_q.rate_hz;
				dreq.start    = !(capturing_q || item_q.other_busy) && item_q.channel_mask != 8'd0
					&& item_q.sample_count != 32'd0 && total_c <= 36'(HALF)
					&& item_q.rate_hz != 32'd0;
			end
			S_PLAN: begin
				dreq.dividend = 32'(period_q);
				dreq.divisor  = 32'(psc_c) + 32'd1;
				dreq.start    = 32'(period_q) >= MIN_TICKS && 32'(period_q) > PSC_SPAN;
			end
			S_ARR: begin
				dreq.dividend = TIMER_CLK;
				dreq.divisor  = prod[31:0];
				dreq.start    = 1'b1;
			end
			S_DIV3: begin
				dreq.dividend = NS_PER_S;
				dreq.divisor  = item_q.rate_hz;
				dreq.start    = drsp.done;
			end
			default: dreq = '0;
		endcase
	end

	// chunk bookkeeping
	logic [HW_W-1:0] cc_w;
	logic [HW_W-1:0] hl_next;
	logic [HW_W-1:0] boff_next;
	logic [31:0]     start_chunk;
	logic [31:0]     next_chunk;
	logic [31:0]     boff32;

	assign cc_w      = HW_W'(chunk_q);
	assign hl_next   = (hw_left_q >= cc_w) ? hw_left_q - cc_w : '0;
	assign boff_next = boff_q + cc_w;
	assign start_chunk = (32'(total_q) > 32'(MAX_CHUNK)) ? 32'(MAX_CHUNK) : 32'(total_q);
	assign next_chunk  = (32'(hl_next) > 32'(MAX_CHUNK)) ? 32'(MAX_CHUNK) : 32'(hl_next);
	assign boff32      = 32'(boff_next);

	logic [31:0] samples32;
	assign samples32 = 32'(samples_q);

	always_comb begin
		out_c = '0;
		unique case (item_q.req_type)
			REQ_START: begin
				out_c.start_status = st_q;
				if (st_q == ST_OK) begin
					out_c.prescaler        = psc_q;
					out_c.reload           = arr_q;
					out_c.achieved_rate_hz = ach_q;
					out_c.chunk_valid      = 1'b1;
					out_c.chunk_length     = start_chunk[15:0];
				end
			end
			REQ_CHUNK: if (capturing_q && !finished_q) begin
				if (hl_next != '0) begin
					out_c.chunk_valid  = 1'b1;
					out_c.chunk_offset = boff32[14:0];
					out_c.chunk_length = next_chunk[15:0];
				end else begin
					out_c.stop_capture = 1'b1;
				end
			end
			REQ_POLL: begin
				priority if (!capturing_q) out_c.poll_state = POLL_IDLE;
				else if (!finished_q)      out_c.poll_state = POLL_RUNNING;
				else begin
					out_c.poll_state       = POLL_DONE;
					out_c.achieved_rate_hz = rate_q;
					out_c.report_samples   = samples32[15:0];
					out_c.report_mask      = mask_q;
				end
			end
			default: ;
		endcase
	end

	assign req_ch.ready = (state_q == S_IDLE);
	assign rsp_ch.valid = out_valid_q;
	assign rsp_ch.data  = out_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (req_ch.valid) item_q <= req_ch.data;
			S_CHK: begin
				nch_q   <= nch_c;
				total_q <= HW_W'(total_c);
				priority if (capturing_q || item_q.other_busy) st_q <= ST_BUSY;
				else if (item_q.channel_mask == 8'd0)          st_q <= ST_BAD_CH;
				else if (item_q.sample_count == 32'd0 || total_c > 36'(HALF))
					st_q <= ST_BAD_CNT;
				else if (item_q.rate_hz == 32'd0)              st_q <= ST_BAD_RATE;
				else                                            st_q <= ST_OK;
			end
			S_DIV1: if (drsp.done) period_q <= drsp.quotient[27:0];
			S_PLAN: begin
				if (32'(period_q) < MIN_TICKS) st_q <= ST_BAD_RATE;
				else if (32'(period_q) <= PSC_SPAN) begin
					psc_q <= '0;
					arr_q <= 16'(period_q - 28'd1);
				end else psc_q <= psc_c[15:0];
			end
			S_DIV2: if (drsp.done) begin
				if (drsp.quotient == 32'd0 || drsp.quotient > PSC_SPAN) st_q <= ST_BAD_RATE;
				else arr_q <= 16'(drsp.quotient - 32'd1);
			end
			S_DIV3: if (drsp.done) ach_q <= drsp.quotient[23:0];
			S_DIV4: if (drsp.done && drsp.quotient < 32'(min_period_ns(nch_q)))
				st_q <= ST_BAD_RATE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			capturing_q <= 1'b0;
			finished_q  <= 1'b0;
			hw_left_q   <= '0;
			boff_q      <= '0;
			chunk_q     <= '0;
			samples_q   <= '0;
			mask_q      <= '0;
			rate_q      <= '0;
			out_q       <= '0;
		end else begin
			out_valid_q <= (state_q == S_PUT && out_free) || (out_valid_q && !rsp_ch.ready);
			unique case (state_q)
				S_IDLE: if (req_ch.valid)
					state_q <= (req_ch.data.req_type == REQ_START) ? S_CHK : S_PUT;
				S_CHK:  state_q <= dreq.start ? S_DIV1 : S_PUT;
				S_DIV1: if (drsp.done) state_q <= S_PLAN;
				S_PLAN: begin
					if (32'(period_q) < MIN_TICKS) state_q <= S_PUT;
					else if (dreq.start)           state_q <= S_DIV2;
					else                           state_q <= S_ARR;
				end
				S_DIV2: if (drsp.done) begin
					if (drsp.quotient == 32'd0 || drsp.quotient > PSC_SPAN) state_q <= S_PUT;
					else state_q <= S_ARR;
				end
				S_ARR:  state_q <= S_DIV3;
				S_DIV3: if (drsp.done) state_q <= S_DIV4;
				S_DIV4: if (drsp.done) state_q <= S_PUT;
				S_PUT: if (out_free) begin
					state_q <= S_IDLE;
					out_q   <= out_c;
					unique case (item_q.req_type)
						REQ_START: if (st_q == ST_OK) begin
							capturing_q <= 1'b1;
							finished_q  <= 1'b0;
							hw_left_q   <= total_q;
							boff_q      <= '0;
							samples_q   <= HW_W'(item_q.sample_count);
							mask_q      <= item_q.channel_mask;
							rate_q      <= ach_q;
							chunk_q     <= start_chunk[15:0];
						end
						REQ_CHUNK: if (capturing_q && !finished_q) begin
							boff_q    <= boff_next;
							hw_left_q <= hl_next;
							if (hl_next != '0) chunk_q <= next_chunk[15:0];
							else finished_q <= 1'b1;
						end
						REQ_POLL: if (capturing_q && finished_q) begin
							capturing_q <= 1'b0;
							finished_q  <= 1'b0;
						end
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_finished_implies_capturing: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> capturing_q) else $error("finished without capture");
	a_running_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(capturing_q && !finished_q) |-> (hw_left_q != '0 && cc_w <= hw_left_q))
		else $error("running capture with no halfwords left");
	a_idle_divider: assert property (@(posedge clk) disable iff (!arst_n)
		req_ch.ready |-> !drsp.busy) else $error("divider busy while idle");
endmodule
